// ===== hw/rtl/rm2eul_pkg.sv =====
// ----------------------------------------------------------------------------
// rm2eul_pkg
// Shared widths, arctangent table and word types for the matrix to euler block
// ----------------------------------------------------------------------------
package rm2eul_pkg;

    localparam int ELEMENT_WIDTH = 16;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int GUARD_SHIFT   = 20;
    // internal angle, 2^31 is pi
    localparam int ZWIDTH        = 32;
    localparam int CORDIC_WIDTH  = ELEMENT_WIDTH + GUARD_SHIFT + 4;
    localparam int SQ_WIDTH      = 2 * ELEMENT_WIDTH;
    localparam int ROOT_STEPS    = ELEMENT_WIDTH;
    localparam int SHIFT_WIDTH   = 5;

    // atan(2^-i), 2^31 is pi
    localparam logic [ZWIDTH-1:0] ATAN_TABLE [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21353447, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef struct packed {
        logic signed [ELEMENT_WIDTH-1:0] m00;
        logic signed [ELEMENT_WIDTH-1:0] m10;
        logic signed [ELEMENT_WIDTH-1:0] m20;
        logic signed [ELEMENT_WIDTH-1:0] m21;
        logic signed [ELEMENT_WIDTH-1:0] m22;
    } in_word_t;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] roll_angle;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
        logic                          singular;
    } out_word_t;

    typedef struct packed {
        logic                valid;
        logic [SQ_WIDTH-1:0] rem;
        logic [SQ_WIDTH-1:0] root;
        in_word_t            word;
    } root_cell_t;

    typedef struct packed {
        logic signed [CORDIC_WIDTH-1:0] x;
        logic signed [CORDIC_WIDTH-1:0] y;
        logic [ZWIDTH-1:0]              z;
        logic                           force_zero;
    } lane_t;

    typedef struct packed {
        logic  valid;
        lane_t roll;
        lane_t pitch;
        lane_t yaw;
    } cordic_cell_t;

endpackage

// ===== hw/rtl/rotation_matrix_to_euler_xyz.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_xyz
// Rotation matrix (Rz*Ry*Rx) to roll, pitch and yaw binary angles
// ----------------------------------------------------------------------------
// One matrix word enters per clock while the chain advances, and words stream
// through a fixed pipeline: a head register holds m00^2+m10^2, ELEMENT_WIDTH
// square root cells take one digit each, CORDIC_STAGES cells run the three atan2
// lanes side by side, and a final register rounds the angles. The whole chain
// advances together; it holds only while the output word waits on out_ready. At
// gimbal lock roll and yaw read zero and singular is set.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_xyz (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rm2eul_pkg::in_word_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rm2eul_pkg::out_word_t out_data
);

    localparam int EW = rm2eul_pkg::ELEMENT_WIDTH;
    localparam int AW = rm2eul_pkg::ANGLE_WIDTH;
    localparam int CW = rm2eul_pkg::CORDIC_WIDTH;
    localparam int ZW = rm2eul_pkg::ZWIDTH;
    localparam int SQ = rm2eul_pkg::SQ_WIDTH;
    localparam int RS = rm2eul_pkg::ROOT_STEPS;
    localparam int CS = rm2eul_pkg::CORDIC_STAGES;
    localparam logic signed [ZW:0] ROUND_HALF = ((ZW+1)'(1) << (ZW - AW)) >> 1;
    localparam logic signed [ZW:0] PITCH_LIM  = (ZW+1)'(1) << (AW - 2);
    localparam logic signed [ZW:0] PITCH_NEG  = -PITCH_LIM;

    logic                     adv;
    rm2eul_pkg::root_cell_t   root_chain [RS+1];
    rm2eul_pkg::cordic_cell_t cordic_chain [CS+1];
    rm2eul_pkg::cordic_cell_t cordic_head;
    rm2eul_pkg::root_cell_t   head_reg;
    rm2eul_pkg::root_cell_t   head_next;
    logic [EW-1:0]            abs00;
    logic [EW-1:0]            abs10;
    logic [EW:0]              root_rounded;
    logic                     singular;
    logic                     out_valid_reg;
    rm2eul_pkg::out_word_t    out_reg;
    rm2eul_pkg::out_word_t    out_next;
    rm2eul_pkg::cordic_cell_t tail;
    logic signed [ZW:0]       roll_wide;
    logic signed [ZW:0]       pitch_wide;
    logic signed [ZW:0]       yaw_wide;

    function automatic rm2eul_pkg::lane_t lane_entry(
        input logic signed [CW-1:0] xs,
        input logic signed [CW-1:0] ys
    );
        rm2eul_pkg::lane_t r;
        logic signed [CW-1:0] xt;
        logic signed [CW-1:0] yt;
        xt = xs <<< rm2eul_pkg::GUARD_SHIFT;
        yt = ys <<< rm2eul_pkg::GUARD_SHIFT;
        r.force_zero = 1'b0;
        r.x = xt;
        r.y = yt;
        r.z = '0;
        // left half plane: rotate by a quarter turn first
        if (xt < 0)
        begin
            if (yt >= 0)
            begin
                r.x = yt;
                r.y = -xt;
                r.z = ZW'(1) << (ZW - 2);
            end
            else
            begin
                r.x = -yt;
                r.y = xt;
                r.z = -(ZW'(1) << (ZW - 2));
            end
        end
        return r;
    endfunction

    function automatic logic signed [ZW:0] to_angle(input logic [ZW-1:0] z);
        logic signed [ZW:0] t;
        t = $signed({z[ZW-1], z}) + ROUND_HALF;
        return t >>> (ZW - AW);
    endfunction

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // squared magnitude of the first column pair
    always_comb
    begin
        abs00 = in_data.m00[EW-1] ? EW'(-in_data.m00) : EW'(in_data.m00);
        abs10 = in_data.m10[EW-1] ? EW'(-in_data.m10) : EW'(in_data.m10);
        head_next.valid = in_valid;
        head_next.rem   = SQ'(abs00) * SQ'(abs00) + SQ'(abs10) * SQ'(abs10);
        head_next.root  = '0;
        head_next.word  = in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else if (adv)
        begin
            head_reg <= head_next;
        end
    end

    assign root_chain[0] = head_reg;

    for (genvar k = 0; k < RS; k++)
    begin : g_root
        localparam logic [SQ-1:0] BIT_WEIGHT = SQ'(1) << (SQ - 2 - 2 * k);
        rm2eul_sqrt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (adv),
            .bit_weight (BIT_WEIGHT),
            .d          (root_chain[k]),
            .q          (root_chain[k+1])
        );
    end

    // round the root and load the three atan2 lanes
    always_comb
    begin
        root_rounded = root_chain[RS].root[EW:0]
            + ((root_chain[RS].rem > root_chain[RS].root) ? (EW+1)'(1) : (EW+1)'(0));
        singular = (root_chain[RS].word.m00 == 0 && root_chain[RS].word.m10 == 0)
            || (root_chain[RS].word.m21 == 0 && root_chain[RS].word.m22 == 0);
        cordic_head.valid = root_chain[RS].valid;
        cordic_head.pitch = lane_entry(CW'(root_rounded),
                                       -CW'(root_chain[RS].word.m20));
        cordic_head.pitch.force_zero = (root_rounded == 0)
            && (root_chain[RS].word.m20 == 0);
        cordic_head.yaw = lane_entry(CW'(root_chain[RS].word.m00),
                                     CW'(root_chain[RS].word.m10));
        cordic_head.yaw.force_zero = singular;
        cordic_head.roll = lane_entry(CW'(root_chain[RS].word.m22),
                                      CW'(root_chain[RS].word.m21));
        cordic_head.roll.force_zero = singular;
    end

    assign cordic_chain[0] = cordic_head;

    for (genvar i = 0; i < CS; i++)
    begin : g_cordic
        rm2eul_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .shift     (rm2eul_pkg::SHIFT_WIDTH'(i)),
            .atan_step (rm2eul_pkg::ATAN_TABLE[i]),
            .d         (cordic_chain[i]),
            .q         (cordic_chain[i+1])
        );
    end

    assign tail = cordic_chain[CS];

    always_comb
    begin
        roll_wide  = to_angle(tail.roll.z);
        pitch_wide = to_angle(tail.pitch.z);
        yaw_wide   = to_angle(tail.yaw.z);
        out_next.singular   = tail.roll.force_zero;
        out_next.roll_angle = tail.roll.force_zero ? '0 : roll_wide[AW-1:0];
        out_next.yaw_angle  = tail.yaw.force_zero ? '0 : yaw_wide[AW-1:0];
        priority if (tail.pitch.force_zero)
        begin
            out_next.pitch_angle = '0;
        end
        else if (pitch_wide > PITCH_LIM)
        begin
            out_next.pitch_angle = PITCH_LIM[AW-1:0];
        end
        else if (pitch_wide < PITCH_NEG)
        begin
            out_next.pitch_angle = PITCH_NEG[AW-1:0];
        end
        else
        begin
            out_next.pitch_angle = pitch_wide[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/rm2eul_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rm2eul_sqrt_cell
// One digit step of the square root, carries the matrix word along
// ----------------------------------------------------------------------------
module rm2eul_sqrt_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic [rm2eul_pkg::SQ_WIDTH-1:0]    bit_weight,
    input  rm2eul_pkg::root_cell_t             d,
    output rm2eul_pkg::root_cell_t             q
);

    rm2eul_pkg::root_cell_t        q_reg;
    rm2eul_pkg::root_cell_t        q_next;
    logic [rm2eul_pkg::SQ_WIDTH:0] trial;

    always_comb
    begin
        q_next = d;
        trial  = {1'b0, d.root} + {1'b0, bit_weight};
        if ({1'b0, d.rem} >= trial)
        begin
            q_next.rem  = d.rem - trial[rm2eul_pkg::SQ_WIDTH-1:0];
            q_next.root = (d.root >> 1) + bit_weight;
        end
        else
        begin
            q_next.root = d.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== hw/rtl/rm2eul_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// rm2eul_cordic_cell
// One vectoring micro-rotation for the roll, pitch and yaw lanes
// ----------------------------------------------------------------------------
module rm2eul_cordic_cell (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic [rm2eul_pkg::SHIFT_WIDTH-1:0]    shift,
    input  logic [rm2eul_pkg::ZWIDTH-1:0]         atan_step,
    input  rm2eul_pkg::cordic_cell_t              d,
    output rm2eul_pkg::cordic_cell_t              q
);

    rm2eul_pkg::cordic_cell_t q_reg;
    rm2eul_pkg::cordic_cell_t q_next;

    function automatic rm2eul_pkg::lane_t rotate(
        input rm2eul_pkg::lane_t                  a,
        input logic [rm2eul_pkg::SHIFT_WIDTH-1:0] sh,
        input logic [rm2eul_pkg::ZWIDTH-1:0]      at
    );
        rm2eul_pkg::lane_t r;
        r = a;
        // drive y toward zero
        if (a.y > 0)
        begin
            r.x = a.x + (a.y >>> sh);
            r.y = a.y - (a.x >>> sh);
            r.z = a.z + at;
        end
        else
        begin
            r.x = a.x - (a.y >>> sh);
            r.y = a.y + (a.x >>> sh);
            r.z = a.z - at;
        end
        return r;
    endfunction

    always_comb
    begin
        q_next       = d;
        q_next.roll  = rotate(d.roll, shift, atan_step);
        q_next.pitch = rotate(d.pitch, shift, atan_step);
        q_next.yaw   = rotate(d.yaw, shift, atan_step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== verif/rotation_matrix_to_euler_xyz_tb.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_xyz_tb
// Streams matrix words through the euler angle block and checks each angle set
// against an in-bench cordic predictor, with random stalls on both sides.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_xyz_tb;

    localparam int EW       = rm2eul_pkg::ELEMENT_WIDTH;
    localparam int AW       = rm2eul_pkg::ANGLE_WIDTH;
    localparam int CS       = rm2eul_pkg::CORDIC_STAGES;
    localparam int GS       = rm2eul_pkg::GUARD_SHIFT;
    localparam int LATENCY  = 2 + EW + CS;
    localparam int N_RANDOM = 1600;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    rm2eul_pkg::in_word_t  in_data;
    logic                  out_valid;
    logic                  out_ready;
    rm2eul_pkg::out_word_t out_data;

    rotation_matrix_to_euler_xyz dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    rm2eul_pkg::in_word_t  pending_words[$];
    rm2eul_pkg::out_word_t expected_angles[$];
    int                    mismatch_count;
    int                    send_wait;
    int                    recv_wait;
    int                    hold_off;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_root(longint n);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= n)
            r = r + ((((r + 1024) * (r + 1024)) <= n) ? 1024 : 1);
        // round half up: n - r^2 > r means closer to r+1
        if (n - r * r > r)
            r = r + 1;
        return r;
    endfunction

    function automatic longint atan2_binary(longint y, longint x);
        longint z, t, nx, ny;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        x = x <<< GS;
        y = y <<< GS;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 64'sd1 <<< 30;
            end
            else
            begin
                x = -y; y = t; z = -(64'sd1 <<< 30);
            end
        end
        for (int i = 0; i < CS; i++)
        begin
            if (y > 0)
            begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z = z + longint'(rm2eul_pkg::ATAN_TABLE[i]);
            end
            else
            begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z = z - longint'(rm2eul_pkg::ATAN_TABLE[i]);
            end
            x = nx;
            y = ny;
        end
        return floor_shift(z + (64'sd1 <<< (31 - AW)), 32 - AW);
    endfunction

    function automatic rm2eul_pkg::out_word_t euler_of(rm2eul_pkg::in_word_t w);
        rm2eul_pkg::out_word_t r;
        longint a, b, c, p, lim, ang;
        a = w.m00;
        b = w.m10;
        c = int_root(a * a + b * b);
        lim = 64'sd1 <<< (AW - 2);
        p = atan2_binary(-longint'(w.m20), c);
        if (p > lim) p = lim;
        if (p < -lim) p = -lim;
        r.pitch_angle = p[AW-1:0];
        r.singular = (w.m00 == 0 && w.m10 == 0) || (w.m21 == 0 && w.m22 == 0);
        r.roll_angle = '0;
        r.yaw_angle = '0;
        if (!r.singular)
        begin
            ang = atan2_binary(w.m10, w.m00);
            r.yaw_angle = ang[AW-1:0];
            ang = atan2_binary(w.m21, w.m22);
            r.roll_angle = ang[AW-1:0];
        end
        return r;
    endfunction

    function automatic rm2eul_pkg::in_word_t make_word(int a, int b, int c, int d, int e);
        rm2eul_pkg::in_word_t w;
        w.m00 = EW'(a); w.m10 = EW'(b); w.m20 = EW'(c); w.m21 = EW'(d); w.m22 = EW'(e);
        return w;
    endfunction

    function automatic logic signed [EW-1:0] rand_entry();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return EW'($urandom);        // full field, out of range too
        if (k == 1) return EW'(int'($urandom_range(0, 6)) - 3);
        return EW'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            send_wait <= 0;
        end
        else if (in_valid && !in_ready)
        begin
        end
        else if (send_wait > 0)
        begin
            in_valid  <= 1'b0;
            send_wait <= send_wait - 1;
        end
        else if (pending_words.size() > 0)
        begin
            in_valid <= 1'b1;
            in_data  <= pending_words[0];
            expected_angles.push_back(euler_of(pending_words[0]));
            void'(pending_words.pop_front());
            send_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
        end
        else
            in_valid <= 1'b0;
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_angles.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected word %h", out_data);
                end
                else
                begin
                    if (out_data !== expected_angles[0])
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                        begin
                            $display("mismatch exp r=%0d p=%0d y=%0d s=%0b",
                                expected_angles[0].roll_angle,
                                expected_angles[0].pitch_angle,
                                expected_angles[0].yaw_angle,
                                expected_angles[0].singular);
                            $display("         act r=%0d p=%0d y=%0d s=%0b",
                                out_data.roll_angle, out_data.pitch_angle,
                                out_data.yaw_angle, out_data.singular);
                        end
                    end
                    void'(expected_angles.pop_front());
                end
            end
            if (hold_off > 0)
                out_ready <= 1'b0;
            else if (recv_wait > 0)
            begin
                out_ready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    recv_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
            end
        end
    end

    // long receiver hold-off so the pipeline backs up into the input
    initial
    begin
        hold_off = 0;
        wait (rst_n);
        repeat (400) @(posedge clk);
        hold_off <= 1;
        repeat (150) @(posedge clk);
        hold_off <= 0;
    end

    initial
    begin
        int s;
        mismatch_count = 0;
        rst_n = 1'b0;
        // directed corners
        pending_words.push_back(make_word(16384, 0, 0, 0, 16384));
        pending_words.push_back(make_word(-16384, 0, 0, 0, -16384));
        pending_words.push_back(make_word(-16384, -1, 0, -1, -16384));
        pending_words.push_back(make_word(0, 16384, 0, 16384, 0));
        pending_words.push_back(make_word(0, -16384, 0, -16384, 0));
        pending_words.push_back(make_word(0, 0, 16384, 100, 200));
        pending_words.push_back(make_word(0, 0, -16384, 100, 200));
        pending_words.push_back(make_word(0, 0, 0, 0, 0));
        pending_words.push_back(make_word(100, 5, 300, 0, 0));
        pending_words.push_back(make_word(1, 0, -32768, 1, 1));
        pending_words.push_back(make_word(1, 0, 32767, -1, 1));
        pending_words.push_back(make_word(-32768, -32768, -32768, -32768, -32768));
        pending_words.push_back(make_word(32767, 32767, 32767, 32767, 32767));
        pending_words.push_back(make_word(-32768, 32767, 0, 32767, -32768));
        pending_words.push_back(make_word(11585, 11585, -11585, 8192, -14189));
        pending_words.push_back(make_word(16384, 16384, 16384, -16384, 16384));
        pending_words.push_back(make_word(-1, 0, 0, 0, -1));
        pending_words.push_back(make_word(-1, 1, 0, 1, -1));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            s = $urandom_range(0, 19);
            if (s == 0)
                pending_words.push_back(make_word(0, 0, rand_entry(), rand_entry(),
                                                  rand_entry()));
            else if (s == 1)
                pending_words.push_back(make_word(rand_entry(), rand_entry(),
                                                  rand_entry(), 0, 0));
            else
                pending_words.push_back(make_word(rand_entry(), rand_entry(),
                                                  rand_entry(), rand_entry(),
                                                  rand_entry()));
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_words.size() == 0);
        @(posedge clk);
        while (in_valid || expected_angles.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0)
            $display("[rotation_matrix_to_euler_xyz] OK");
        else
            $display("[rotation_matrix_to_euler_xyz] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[rotation_matrix_to_euler_xyz] ERROR");
        $finish;
    end

endmodule
